// ===== rtl/btok_pkg.sv =====
package btok_pkg;

  // Field widths of the token word
  localparam int LINE_BITS   = 24;
  localparam int COLUMN_BITS = 16;
  localparam int LENGTH_BITS = 16;
  localparam int KIND_BITS   = 5;

  // Word prefix kept for keyword matching
  localparam int PREFIX_DEPTH = 6;
  localparam int PREFIX_IDX_BITS = $clog2(PREFIX_DEPTH);

  // Token queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // Token kinds
  localparam logic [KIND_BITS-1:0] KIND_EOF    = 5'd0;
  localparam logic [KIND_BITS-1:0] KIND_LPAR   = 5'd1;
  localparam logic [KIND_BITS-1:0] KIND_RPAR   = 5'd2;
  localparam logic [KIND_BITS-1:0] KIND_EQ     = 5'd3;
  localparam logic [KIND_BITS-1:0] KIND_COMMA  = 5'd4;
  localparam logic [KIND_BITS-1:0] KIND_INPUT  = 5'd5;
  localparam logic [KIND_BITS-1:0] KIND_OUTPUT = 5'd6;
  localparam logic [KIND_BITS-1:0] KIND_BUFF   = 5'd7;
  localparam logic [KIND_BITS-1:0] KIND_NOT    = 5'd8;
  localparam logic [KIND_BITS-1:0] KIND_AND    = 5'd9;
  localparam logic [KIND_BITS-1:0] KIND_NAND   = 5'd10;
  localparam logic [KIND_BITS-1:0] KIND_OR     = 5'd11;
  localparam logic [KIND_BITS-1:0] KIND_NOR    = 5'd12;
  localparam logic [KIND_BITS-1:0] KIND_XOR    = 5'd13;
  localparam logic [KIND_BITS-1:0] KIND_XNOR   = 5'd14;
  localparam logic [KIND_BITS-1:0] KIND_DFF    = 5'd15;
  localparam logic [KIND_BITS-1:0] KIND_NAME   = 5'd16;

  // Keyword table: first byte in the low bits, unused bytes zero
  localparam int NUM_KW = 12;
  localparam logic [8*PREFIX_DEPTH-1:0] KW_TEXT [NUM_KW] = '{
    48'h00_54_55_50_4E_49,  // INPUT
    48'h54_55_50_54_55_4F,  // OUTPUT
    48'h00_00_46_46_55_42,  // BUFF
    48'h00_00_00_54_4F_4E,  // NOT
    48'h00_00_00_56_4E_49,  // INV
    48'h00_00_00_44_4E_41,  // AND
    48'h00_00_44_4E_41_4E,  // NAND
    48'h00_00_00_00_52_4F,  // OR
    48'h00_00_00_52_4F_4E,  // NOR
    48'h00_00_00_52_4F_58,  // XOR
    48'h00_00_52_4F_4E_58,  // XNOR
    48'h00_00_00_46_46_44   // DFF
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd5, 3'd6, 3'd4, 3'd3, 3'd3, 3'd3, 3'd4, 3'd2, 3'd3, 3'd3, 3'd4, 3'd3
  };
  localparam logic [KIND_BITS-1:0] KW_KIND [NUM_KW] = '{
    KIND_INPUT, KIND_OUTPUT, KIND_BUFF, KIND_NOT, KIND_NOT, KIND_AND,
    KIND_NAND, KIND_OR, KIND_NOR, KIND_XOR, KIND_XNOR, KIND_DFF
  };

  // Scanner mode; the fourth code acts as idle
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_WORD    = 2'd2
  } mode_t;

  typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]   token_kind;
    logic [LINE_BITS-1:0]   start_line;
    logic [COLUMN_BITS-1:0] start_column;
    logic [LENGTH_BITS-1:0] word_length;
    logic                   last_of_item;
  } out_t;

  // Tokens produced by one item, in order
  typedef struct packed {
    logic [1:0] cnt;
    out_t       tok0;
    out_t       tok1;
  } push_t;

  function automatic logic ends_word(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_HASH ||
           c == CH_EQ || c == CH_LPAR || c == CH_RPAR || c == CH_COMMA;
  endfunction

  // Keyword match; bytes past the word length are always zero
  function automatic logic [KIND_BITS-1:0] word_kind(
    input prefix_t                prefix,
    input logic [LENGTH_BITS-1:0] count
  );
    logic [KIND_BITS-1:0] kind;
    kind = KIND_NAME;
    for (int i = 0; i < NUM_KW; i++) begin
      if (count == LENGTH_BITS'(KW_LEN[i]) && prefix == KW_TEXT[i]) begin
        kind = KW_KIND[i];
      end
    end
    return kind;
  endfunction

endpackage

// ===== rtl/btok_core.sv =====
module btok_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  btok_pkg::in_t item,
  output btok_pkg::push_t push
);
  import btok_pkg::*;

  mode_t                  mode_r, mode_nxt;
  prefix_t                prefix_r, prefix_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;
  logic [LINE_BITS-1:0]   tline_r, tline_nxt;
  logic [COLUMN_BITS-1:0] tcol_r, tcol_nxt;

  logic [7:0] c;
  logic       eof;
  logic       in_word, in_comment, word_end, word_go, start_word;
  logic       other_vld;
  out_t       word_tok, other_tok;

  assign c          = item.char_byte;
  assign eof        = item.end_of_file;
  assign in_word    = (mode_r == MODE_WORD);
  assign in_comment = (mode_r == MODE_COMMENT);
  assign word_end   = in_word && (eof || ends_word(c));
  assign word_go    = in_word && !word_end;
  assign start_word = !in_word && !in_comment && !eof && !ends_word(c);

  // Next scanner mode
  always_comb begin
    mode_nxt = MODE_IDLE;
    if (eof) begin
      mode_nxt = MODE_IDLE;
    end else begin
      unique case (mode_r)
        MODE_WORD: begin
          mode_nxt = word_go ? MODE_WORD : ((c == CH_HASH) ? MODE_COMMENT : MODE_IDLE);
        end
        MODE_COMMENT: begin
          mode_nxt = (c == CH_NL) ? MODE_IDLE : MODE_COMMENT;
        end
        default: begin
          if (c == CH_HASH) begin
            mode_nxt = MODE_COMMENT;
          end else if (start_word) begin
            mode_nxt = MODE_WORD;
          end else begin
            mode_nxt = MODE_IDLE;
          end
        end
      endcase
    end
  end

  // Tokens, position and word buffer
  always_comb begin
    word_tok.token_kind   = word_kind(prefix_r, count_r);
    word_tok.start_line   = tline_r;
    word_tok.start_column = tcol_r;
    word_tok.word_length  = count_r;
    word_tok.last_of_item = 1'b0;

    other_tok.token_kind   = KIND_EOF;
    other_tok.start_line   = line_r;
    other_tok.start_column = col_r;
    other_tok.word_length  = '0;
    other_tok.last_of_item = 1'b1;
    other_vld = 1'b0;

    if (!word_go) begin
      if (eof) begin
        other_vld = 1'b1;
      end else if (!in_comment) begin
        case (c)
          CH_EQ:    begin other_vld = 1'b1; other_tok.token_kind = KIND_EQ;    end
          CH_LPAR:  begin other_vld = 1'b1; other_tok.token_kind = KIND_LPAR;  end
          CH_RPAR:  begin other_vld = 1'b1; other_tok.token_kind = KIND_RPAR;  end
          CH_COMMA: begin other_vld = 1'b1; other_tok.token_kind = KIND_COMMA; end
          default:  other_vld = 1'b0;
        endcase
      end
    end

    // Position moves on every byte, saturating
    line_nxt = line_r;
    col_nxt  = col_r;
    if (!eof) begin
      if (c == CH_NL) begin
        if (line_r != '1) line_nxt = line_r + 1'b1;
        col_nxt = COLUMN_BITS'(1);
      end else if (col_r != '1) begin
        col_nxt = col_r + 1'b1;
      end
    end

    prefix_nxt = prefix_r;
    count_nxt  = count_r;
    tline_nxt  = tline_r;
    tcol_nxt   = tcol_r;
    if (word_go) begin
      if (count_r < LENGTH_BITS'(PREFIX_DEPTH)) begin
        prefix_nxt[count_r[PREFIX_IDX_BITS-1:0]] = c;
      end
      if (count_r != '1) count_nxt = count_r + 1'b1;
    end else if (start_word) begin
      prefix_nxt    = '0;
      prefix_nxt[0] = c;
      count_nxt     = LENGTH_BITS'(1);
      tline_nxt     = line_r;
      tcol_nxt      = col_r;
    end

    // Word token goes first when both are present
    push.cnt = step ? {word_end && other_vld, word_end ^ other_vld} : 2'd0;
    if (word_end) begin
      push.tok0 = word_tok;
      push.tok0.last_of_item = !other_vld;
    end else begin
      push.tok0 = other_tok;
    end
    push.tok1 = other_tok;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      prefix_r <= '0;
      count_r  <= '0;
      line_r   <= LINE_BITS'(1);
      col_r    <= COLUMN_BITS'(1);
      tline_r  <= LINE_BITS'(1);
      tcol_r   <= COLUMN_BITS'(1);
    end else if (step) begin
      mode_r   <= mode_nxt;
      prefix_r <= prefix_nxt;
      count_r  <= count_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      tline_r  <= tline_nxt;
      tcol_r   <= tcol_nxt;
    end
  end

endmodule

// ===== rtl/btok_fifo.sv =====
module btok_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  btok_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output btok_pkg::out_t  out_data
);
  import btok_pkg::*;

  out_t                mem_r [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                pop;

  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  // Room for the two tokens one item can give
  assign room      = (cnt_r <= CNT_BITS'(FIFO_DEPTH - 2));

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_BITS'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_BITS'(pop);
    cnt_nxt    = cnt_r + CNT_BITS'(push.cnt) - CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Token storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r] <= push.tok0;
    if (push.cnt == 2'd2) mem_r[wr_ptr_p1] <= push.tok1;
  end

endmodule

// ===== rtl/bench_netlist_tokenizer.sv =====
// Lexer for gate-level .bench netlist text. Each input word is one byte or an
// end-of-file mark; each output word is one token with its kind, the line and
// column of its first byte, its length (words only) and a flag on the last
// token caused by that input. Input words are taken one per cycle while the
// queue has room: a byte goes into an input register, is scanned against the
// scanner state as it leaves that register, and its tokens land in a
// four-entry token queue. A byte that ends a word and is itself punctuation,
// or an end-of-file mark after a word, gives two tokens; these drain at one
// per cycle while out_ready is high. Scanning waits, and input is held off once
// the input register is full, while the queue has fewer than two free entries.
module bench_netlist_tokenizer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  btok_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output btok_pkg::out_t out_data
);
  import btok_pkg::*;

  in_t   item_r;
  logic  item_vld_r;
  logic  room, fire;
  push_t push;

  assign fire     = item_vld_r && room;
  assign in_ready = !item_vld_r || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) item_r <= in_data;
  end

  btok_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (fire),
    .item  (item_r),
    .push  (push)
  );

  btok_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import btok_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_WORDS = 850;
  localparam int IDLE_PCT     = 19;

  // Token predictor and queue of tokens still owed by the block
  class token_scoreboard;
    out_t                   expected_tokens[$];
    mode_t                  mode;
    logic [7:0]             prefix[PREFIX_DEPTH];
    logic [LENGTH_BITS-1:0] word_len;
    logic [LINE_BITS-1:0]   line_now;
    logic [LINE_BITS-1:0]   word_line;
    logic [COLUMN_BITS-1:0] col_now;
    logic [COLUMN_BITS-1:0] word_col;
    string                  kw_name[NUM_KW];
    logic [KIND_BITS-1:0]   kw_kind[NUM_KW];
    int unsigned            failures;
    int unsigned            checked;
    int unsigned            words_in;
    logic [31:0]            kinds_seen;

    function new();
      kw_name = '{"INPUT", "OUTPUT", "BUFF", "NOT", "INV", "AND",
                  "NAND", "OR", "NOR", "XOR", "XNOR", "DFF"};
      kw_kind = '{KIND_INPUT, KIND_OUTPUT, KIND_BUFF, KIND_NOT, KIND_NOT,
                  KIND_AND, KIND_NAND, KIND_OR, KIND_NOR, KIND_XOR,
                  KIND_XNOR, KIND_DFF};
      mode = MODE_IDLE;
      foreach (prefix[i]) prefix[i] = 8'h00;
      word_len = '0;
      line_now = 1;
      word_line = 1;
      col_now = 1;
      word_col = 1;
      failures = 0;
      checked = 0;
      words_in = 0;
      kinds_seen = '0;
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    // Keyword lookup on the kept prefix; anything else is a name
    function logic [KIND_BITS-1:0] classify_word();
      bit match;
      for (int i = 0; i < NUM_KW; i++) begin
        if (word_len == LENGTH_BITS'(kw_name[i].len())) begin
          match = 1;
          for (int j = 0; j < kw_name[i].len(); j++) begin
            if (prefix[j] != kw_name[i][j]) match = 0;
          end
          if (match) return kw_kind[i];
        end
      end
      return KIND_NAME;
    endfunction

    function bit is_break(logic [7:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_NL, CH_HASH, CH_EQ, CH_LPAR,
                       CH_RPAR, CH_COMMA};
    endfunction

    function void queue_token(logic [KIND_BITS-1:0] kind,
                              logic [LINE_BITS-1:0] line,
                              logic [COLUMN_BITS-1:0] col,
                              logic [LENGTH_BITS-1:0] len);
      out_t t;
      t.token_kind   = kind;
      t.start_line   = line;
      t.start_column = col;
      t.word_length  = len;
      t.last_of_item = 1'b0;
      expected_tokens.push_back(t);
    endfunction

    // Every byte moves the position; both counters stick at all ones
    function void advance(logic [7:0] c);
      if (c == CH_NL) begin
        if (line_now != '1) line_now++;
        col_now = 1;
      end else if (col_now != '1) begin
        col_now++;
      end
    endfunction

    function void take_byte(in_t w);
      logic [7:0] c;
      bit         eof;
      int         queued_at_start;
      c = w.char_byte;
      eof = w.end_of_file;
      queued_at_start = expected_tokens.size();
      words_in++;

      // A pending word closes first, or swallows the byte
      if (mode == MODE_WORD) begin
        if (eof || is_break(c)) begin
          queue_token(classify_word(), word_line, word_col, word_len);
          mode = MODE_IDLE;
        end else begin
          if (word_len < PREFIX_DEPTH) prefix[word_len] = c;
          if (word_len != '1) word_len++;
          advance(c);
          return;
        end
      end

      if (eof) begin
        mode = MODE_IDLE;
        queue_token(KIND_EOF, line_now, col_now, '0);
      end else begin
        if (mode == MODE_COMMENT) begin
          if (c == CH_NL) mode = MODE_IDLE;
        end else begin
          mode = MODE_IDLE;
          case (c)
            CH_SPACE, CH_TAB, CH_NL: ;
            CH_HASH:  mode = MODE_COMMENT;
            CH_EQ:    queue_token(KIND_EQ, line_now, col_now, '0);
            CH_LPAR:  queue_token(KIND_LPAR, line_now, col_now, '0);
            CH_RPAR:  queue_token(KIND_RPAR, line_now, col_now, '0);
            CH_COMMA: queue_token(KIND_COMMA, line_now, col_now, '0);
            default: begin
              foreach (prefix[i]) prefix[i] = 8'h00;
              prefix[0] = c;
              word_len = 1;
              word_line = line_now;
              word_col = col_now;
              mode = MODE_WORD;
            end
          endcase
        end
        advance(c);
      end

      if (expected_tokens.size() > queued_at_start) expected_tokens[$].last_of_item = 1'b1;
    endfunction

    function void check_token(out_t got);
      out_t exp;
      if (expected_tokens.size() == 0) begin
        $error("unexpected token: kind %0d line %0d column %0d",
               got.token_kind, got.start_line, got.start_column);
        failures++;
        return;
      end
      exp = expected_tokens.pop_front();
      checked++;
      kinds_seen[got.token_kind] = 1'b1;
      if (got.token_kind !== exp.token_kind) begin
        $error("token_kind: expected %0d, got %0d", exp.token_kind, got.token_kind);
        failures++;
      end
      if (got.start_line !== exp.start_line) begin
        $error("start_line: expected %0d, got %0d", exp.start_line, got.start_line);
        failures++;
      end
      if (got.start_column !== exp.start_column) begin
        $error("start_column: expected %0d, got %0d", exp.start_column, got.start_column);
        failures++;
      end
      if (got.word_length !== exp.word_length) begin
        $error("word_length: expected %0d, got %0d", exp.word_length, got.word_length);
        failures++;
      end
      if (got.last_of_item !== exp.last_of_item) begin
        $error("last_of_item: expected %0d, got %0d", exp.last_of_item, got.last_of_item);
        failures++;
      end
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  token_scoreboard sb = new();
  bit              quiet = 0;
  int unsigned     sent = 0;
  int unsigned     cycles = 0;

  string io_words[2]    = '{"INPUT", "OUTPUT"};
  string gate_words[10] = '{"BUFF", "NOT", "INV", "AND", "NAND", "OR", "NOR",
                            "XOR", "XNOR", "DFF"};

  bench_netlist_tokenizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Handshake monitor: check results, then predict from accepted bytes
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_token(out_data);
      if (in_valid && in_ready) sb.take_byte(in_data);
    end
  end

  // One input word, with a random gap ahead of it
  task automatic send_word(in_t w);
    quiet = (sent >= 350 && sent < 520);
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic push_byte(logic [7:0] c);
    in_t w;
    w.char_byte = c;
    w.end_of_file = 1'b0;
    send_word(w);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // End-of-file mark; the byte beside it is junk
  task automatic push_eof();
    in_t w;
    w.char_byte = 8'($urandom_range(0, 255));
    w.end_of_file = 1'b1;
    send_word(w);
  endtask

  task automatic push_gap();
    int n;
    n = $urandom_range(0, 2);
    repeat (n) push_byte(($urandom_range(0, 3) == 0) ? CH_TAB : CH_SPACE);
  endtask

  // Signal names: mostly plain, some near or on keywords, some odd bytes
  task automatic push_name();
    int         pick;
    string      s;
    logic [7:0] c;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      push_text($sformatf("G%0d", $urandom_range(0, 9999)));
    end else if (pick == 6) begin
      push_text(gate_words[$urandom_range(0, 9)]);
    end else if (pick == 7) begin
      s = ($urandom_range(0, 1) == 0) ? io_words[$urandom_range(0, 1)]
                                      : gate_words[$urandom_range(0, 9)];
      if ($urandom_range(0, 1) == 0 && s.len() > 1) s = s.substr(0, s.len() - 2);
      else s = {s, "X"};
      push_text(s);
    end else begin
      repeat ($urandom_range(1, 8)) begin
        c = (pick == 8) ? 8'($urandom_range(8'h21, 8'h7E)) : 8'($urandom_range(0, 255));
        if (sb.is_break(c)) c = (pick == 8) ? 8'h5F : 8'hC3;
        push_byte(c);
      end
    end
  endtask

  // One line of netlist text, or noise
  task automatic emit_line();
    int pick;
    int nargs;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      push_text(io_words[$urandom_range(0, 1)]);
      push_gap(); push_byte(CH_LPAR); push_gap();
      push_name();
      push_gap(); push_byte(CH_RPAR);
      push_byte(CH_NL);
    end else if (pick < 60) begin
      push_name();
      push_gap(); push_byte(CH_EQ); push_gap();
      push_text(gate_words[$urandom_range(0, 9)]);
      push_gap(); push_byte(CH_LPAR);
      nargs = $urandom_range(1, 4);
      for (int i = 0; i < nargs; i++) begin
        if (i > 0) begin
          push_byte(CH_COMMA); push_gap();
        end
        push_name();
      end
      push_byte(CH_RPAR);
      if ($urandom_range(0, 4) == 0) push_text(" #note");
      push_byte(CH_NL);
    end else if (pick < 70) begin
      push_byte(CH_HASH);
      repeat ($urandom_range(0, 10)) push_byte(8'($urandom_range(8'h20, 8'hFF)));
      push_byte(CH_NL);
    end else if (pick < 78) begin
      push_gap(); push_byte(CH_NL);
    end else if (pick < 93) begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 7) == 0) push_eof();
        else push_byte(8'($urandom_range(0, 255)));
      end
    end else begin
      // truncated line closed by end of file
      if ($urandom_range(0, 1) == 0) push_name();
      push_eof();
    end
  endtask

  // Hold input off until the block owes nothing
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    bit paused;
    paused = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: word cut by punctuation, extreme bytes, all punctuation,
    // eof inside a comment, eof after a word, bare eof, carriage return
    push_text("INV(");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text(" ,=)\t");
    push_text("#c");
    push_eof();
    push_text("OR");
    push_eof();
    push_eof();
    push_byte(8'h0D);
    push_byte(CH_NL);

    // Random netlist text with noise mixed in
    while (sent < RANDOM_WORDS + 20) begin
      emit_line();
      if (!paused && sent >= 250) begin
        wait_drained();
        paused = 1;
      end
    end
    push_byte(CH_NL);
    push_eof();

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected tokens never arrived", sb.pending());
      sb.failures++;
    end

    $display("Run summary: %0d input words, %0d tokens checked, %0d of 17 kinds seen.",
             sb.words_in, sb.checked, $countones(sb.kinds_seen));
    $display("Covered netlist lines, comments, raw bytes, eof marks and stalls on both sides.");
    if (sb.failures == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
